// ----- hw/rtl/lafifo_pkg.sv -----
package lafifo_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam int MAX_RESULTS = 62;

  typedef enum logic [1:0] {
    MODE_RECV = 2'd0,
    MODE_POP  = 2'd1,
    MODE_LINE = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DROP   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOLINE = 2'd3
  } rx_status_t;

  typedef enum logic [1:0] {
    CNT_FILL,
    CNT_ZERO,
    CNT_LINE
  } cnt_sel_t;

  typedef enum logic [1:0] {
    RD_READ,
    RD_SCAN,
    RD_EMIT
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_RD,
    S_POP_LD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FOUND,
    S_EMIT_RD,
    S_EMIT_LD,
    S_OUT,
    S_TAIL_RD,
    S_TAIL_CHK
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       write;
    logic       scan_init;
    logic       scan_step;
    logic       found;
    logic       emit_step;
    logic       pop;
    logic       jump;
    logic       load;
    rd_sel_t    rd_sel;
    logic       ld_mem_data;
    logic       ld_last_k;
    cnt_sel_t   ld_count;
    rx_status_t ld_status;
  } ctl_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  ml_zero;
    logic  scan_end;
    logic  eol;
    logic  n_zero;
    logic  out_fire;
    logic  out_last;
    logic  line_hit;
  } dp_stat_t;

endpackage

// ----- hw/rtl/lafifo_if.sv -----
interface lafifo_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] byte_in;
  logic [7:0] max_length;

  modport source (output valid, output mode, output byte_in, output max_length, input ready);
  modport sink (input valid, input mode, input byte_in, input max_length, output ready);
endinterface

interface lafifo_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       data_valid;
  logic       last;
  logic [5:0] count;
  logic [1:0] status;

  modport source (
    output valid, output data, output data_valid, output last, output count, output status,
    input ready
  );
  modport sink (
    input valid, input data, input data_valid, input last, input count, input status,
    output ready
  );
endinterface

// ----- hw/rtl/lafifo_ctrl.sv -----
module lafifo_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  lafifo_pkg::dp_stat_t stat,
  output lafifo_pkg::ctl_t     ctl
);

  lafifo_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lafifo_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lafifo_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_next = lafifo_pkg::S_DISPATCH;
        end
      end
      lafifo_pkg::S_DISPATCH: begin
        unique case (stat.mode)
          lafifo_pkg::MODE_POP:  state_next = stat.empty ? lafifo_pkg::S_OUT
                                                         : lafifo_pkg::S_POP_RD;
          lafifo_pkg::MODE_LINE: state_next = stat.ml_zero ? lafifo_pkg::S_OUT
                                                           : lafifo_pkg::S_SCAN_RD;
          default:               state_next = lafifo_pkg::S_OUT;
        endcase
      end
      lafifo_pkg::S_POP_RD:  state_next = lafifo_pkg::S_POP_LD;
      lafifo_pkg::S_POP_LD:  state_next = lafifo_pkg::S_OUT;
      lafifo_pkg::S_SCAN_RD: begin
        state_next = stat.scan_end ? lafifo_pkg::S_OUT : lafifo_pkg::S_SCAN_CHK;
      end
      lafifo_pkg::S_SCAN_CHK: begin
        state_next = stat.eol ? lafifo_pkg::S_FOUND : lafifo_pkg::S_SCAN_RD;
      end
      lafifo_pkg::S_FOUND: begin
        state_next = stat.n_zero ? lafifo_pkg::S_OUT : lafifo_pkg::S_EMIT_RD;
      end
      lafifo_pkg::S_EMIT_RD: state_next = lafifo_pkg::S_EMIT_LD;
      lafifo_pkg::S_EMIT_LD: state_next = lafifo_pkg::S_OUT;
      lafifo_pkg::S_OUT: begin
        if (stat.out_fire) begin
          if (!stat.out_last) begin
            state_next = lafifo_pkg::S_EMIT_RD;
          end else if (stat.line_hit) begin
            state_next = lafifo_pkg::S_TAIL_RD;
          end else begin
            state_next = lafifo_pkg::S_IDLE;
          end
        end
      end
      lafifo_pkg::S_TAIL_RD: begin
        state_next = stat.empty ? lafifo_pkg::S_IDLE : lafifo_pkg::S_TAIL_CHK;
      end
      lafifo_pkg::S_TAIL_CHK: state_next = lafifo_pkg::S_IDLE;
      default:                state_next = lafifo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.rd_sel    = lafifo_pkg::RD_READ;
    ctl.ld_count  = lafifo_pkg::CNT_FILL;
    ctl.ld_status = lafifo_pkg::ST_OK;
    cmd_ready     = 1'b0;
    unique case (state)
      lafifo_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        ctl.latch = cmd_valid;
      end
      lafifo_pkg::S_DISPATCH: begin
        unique case (stat.mode)
          lafifo_pkg::MODE_RECV: begin
            ctl.write     = 1'b1;
            ctl.load      = 1'b1;
            ctl.ld_status = stat.full ? lafifo_pkg::ST_DROP : lafifo_pkg::ST_OK;
          end
          lafifo_pkg::MODE_POP: begin
            if (stat.empty) begin
              ctl.load      = 1'b1;
              ctl.ld_count  = lafifo_pkg::CNT_ZERO;
              ctl.ld_status = lafifo_pkg::ST_EMPTY;
            end
          end
          lafifo_pkg::MODE_LINE: begin
            if (stat.ml_zero) begin
              ctl.load     = 1'b1;
              ctl.ld_count = lafifo_pkg::CNT_ZERO;
            end else begin
              ctl.scan_init = 1'b1;
            end
          end
          default: begin
            ctl.load = 1'b1;
          end
        endcase
      end
      lafifo_pkg::S_POP_RD: ctl.rd_sel = lafifo_pkg::RD_READ;
      lafifo_pkg::S_POP_LD: begin
        ctl.pop         = 1'b1;
        ctl.load        = 1'b1;
        ctl.ld_mem_data = 1'b1;
      end
      lafifo_pkg::S_SCAN_RD: begin
        ctl.rd_sel = lafifo_pkg::RD_SCAN;
        if (stat.scan_end) begin
          ctl.load      = 1'b1;
          ctl.ld_count  = lafifo_pkg::CNT_ZERO;
          ctl.ld_status = lafifo_pkg::ST_NOLINE;
        end
      end
      lafifo_pkg::S_SCAN_CHK: begin
        ctl.found     = stat.eol;
        ctl.scan_step = !stat.eol;
      end
      lafifo_pkg::S_FOUND: begin
        if (stat.n_zero) begin
          ctl.load     = 1'b1;
          ctl.ld_count = lafifo_pkg::CNT_ZERO;
        end
      end
      lafifo_pkg::S_EMIT_RD: ctl.rd_sel = lafifo_pkg::RD_EMIT;
      lafifo_pkg::S_EMIT_LD: begin
        ctl.load        = 1'b1;
        ctl.ld_mem_data = 1'b1;
        ctl.ld_last_k   = 1'b1;
        ctl.ld_count    = lafifo_pkg::CNT_LINE;
        ctl.emit_step   = 1'b1;
      end
      lafifo_pkg::S_OUT: begin
        ctl.jump = stat.out_fire && stat.out_last && stat.line_hit;
      end
      lafifo_pkg::S_TAIL_RD: ctl.rd_sel = lafifo_pkg::RD_READ;
      lafifo_pkg::S_TAIL_CHK: ctl.pop = stat.eol;
      default: ctl.rd_sel = lafifo_pkg::RD_READ;
    endcase
  end

endmodule

// ----- hw/rtl/lafifo_dp.sv -----
module lafifo_dp #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lafifo_pkg::ctl_t     ctl,
  output lafifo_pkg::dp_stat_t stat,
  input  logic [1:0]           mode,
  input  logic [7:0]           byte_in,
  input  logic [7:0]           max_length,
  input  logic                 rsp_ready,
  output logic                 rsp_valid,
  output logic [7:0]           data,
  output logic                 data_valid,
  output logic                 last,
  output logic [5:0]           count,
  output logic [1:0]           status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > 6) ? AW : 6;

  logic [7:0] mem [DEPTH];

  logic [1:0]    mode_q;
  logic [7:0]    byte_q;
  logic [7:0]    ml_q;
  logic [AW-1:0] wr_idx, rd_idx, scan_ptr, emit_ptr, walked;
  logic [AW-1:0] wr_idx_next, rd_idx_next, rd_addr, fill_next;
  logic [7:0]    rdata;
  logic [5:0]    line_n, k;
  logic          line_hit;
  logic          full, empty, eol;
  logic [7:0]    ml_m1;
  logic [5:0]    cap;
  logic [CW-1:0] walked_w, cap_w, fill_w;

  logic                   out_valid, o_dvalid, o_last;
  logic [7:0]             o_data;
  logic [5:0]             o_count;
  lafifo_pkg::rx_status_t o_status;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] fill_of(input logic [AW-1:0] w, input logic [AW-1:0] r);
    logic [AW:0] t;
    t = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      t = t + (AW + 1)'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  assign full  = (nxt(wr_idx) == rd_idx);
  assign empty = (rd_idx == wr_idx);
  assign eol   = (rdata == lafifo_pkg::CH_LF) || (rdata == lafifo_pkg::CH_CR);

  assign wr_idx_next = (ctl.write && !full) ? nxt(wr_idx) : wr_idx;
  always_comb begin
    rd_idx_next = rd_idx;
    if (ctl.pop) begin
      rd_idx_next = nxt(rd_idx);
    end else if (ctl.jump) begin
      rd_idx_next = nxt(scan_ptr);
    end
  end

  assign fill_next = fill_of(wr_idx_next, rd_idx_next);
  assign fill_w    = CW'(fill_next);

  always_comb begin
    unique case (ctl.rd_sel)
      lafifo_pkg::RD_SCAN: rd_addr = scan_ptr;
      lafifo_pkg::RD_EMIT: rd_addr = emit_ptr;
      default:             rd_addr = rd_idx;
    endcase
  end

  // line length is the distance to the terminator, capped
  assign ml_m1    = ml_q - 8'd1;
  assign cap      = (ml_m1 > 8'(lafifo_pkg::MAX_RESULTS)) ? 6'(lafifo_pkg::MAX_RESULTS)
                                                          : ml_m1[5:0];
  assign walked_w = CW'(walked);
  assign cap_w    = CW'(cap);

  always_ff @(posedge clk) begin
    if (ctl.write && !full) begin
      mem[wr_idx] <= byte_q;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      mode_q <= mode;
      byte_q <= byte_in;
      ml_q   <= max_length;
    end
    if (ctl.scan_init) begin
      scan_ptr <= rd_idx;
      walked   <= '0;
    end else if (ctl.scan_step) begin
      scan_ptr <= nxt(scan_ptr);
      walked   <= walked + AW'(1);
    end
    if (ctl.found) begin
      line_n   <= (walked_w < cap_w) ? walked_w[5:0] : cap;
      emit_ptr <= rd_idx;
      k        <= '0;
    end else if (ctl.emit_step) begin
      emit_ptr <= nxt(emit_ptr);
      k        <= k + 6'd1;
    end
    if (ctl.load) begin
      o_data   <= ctl.ld_mem_data ? rdata : 8'd0;
      o_dvalid <= ctl.ld_mem_data;
      o_last   <= ctl.ld_last_k ? (k == line_n - 6'd1) : 1'b1;
      o_status <= ctl.ld_status;
      case (ctl.ld_count)
        lafifo_pkg::CNT_FILL: o_count <= fill_w[5:0];
        lafifo_pkg::CNT_LINE: o_count <= line_n;
        default:              o_count <= 6'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx    <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
      line_hit  <= 1'b0;
    end else begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      if (ctl.load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.latch) begin
        line_hit <= 1'b0;
      end else if (ctl.found) begin
        line_hit <= 1'b1;
      end
    end
  end

  assign stat.mode     = lafifo_pkg::mode_t'(mode_q);
  assign stat.full     = full;
  assign stat.empty    = empty;
  assign stat.ml_zero  = (ml_q == 8'd0);
  assign stat.scan_end = (scan_ptr == wr_idx);
  assign stat.eol      = eol;
  assign stat.n_zero   = (line_n == 6'd0);
  assign stat.out_fire = out_valid && rsp_ready;
  assign stat.out_last = o_last;
  assign stat.line_hit = line_hit;

  assign rsp_valid  = out_valid;
  assign data       = o_data;
  assign data_valid = o_dvalid;
  assign last       = o_last;
  assign count      = o_count;
  assign status     = o_status;

endmodule

// ----- hw/rtl/line_assembling_receive_fifo.sv -----
// receive and no-op: latched, then the result is loaded in dispatch; pop: dispatch, ram read, load
// line read: dispatch, then a read and a check state per byte walked through the terminator (a last
// read state ends the scan if there is none), then a state to size the line, then per line byte a
// read state, a load state and its output transfer; after the last result a tail read and check drop a trailing cr/lf
// one command at a time; the next is taken once the last result has been transferred
// synchronous reset empties the ring (both indices to zero) and drops any pending result
module line_assembling_receive_fifo #(
  parameter int DEPTH = 64
) (
  input logic          clk,
  input logic          rst,
  lafifo_cmd_if.sink   cmd,
  lafifo_rsp_if.source rsp
);

  lafifo_pkg::ctl_t     ctl;
  lafifo_pkg::dp_stat_t stat;

  lafifo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  lafifo_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .mode       (cmd.mode),
    .byte_in    (cmd.byte_in),
    .max_length (cmd.max_length),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .data       (rsp.data),
    .data_valid (rsp.data_valid),
    .last       (rsp.last),
    .count      (rsp.count),
    .status     (rsp.status)
  );

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !cmd.ready) else $error("command taken while result pending");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data_valid |-> rsp.data == 8'd0) else $error("stray data byte");

  a_more_has_data: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |-> rsp.data_valid && rsp.status == lafifo_pkg::ST_OK)
    else $error("non-final result without a byte");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !rsp.valid || rsp.ready) else $error("result overwritten");

endmodule
